/* rtl/tcw_pkg.sv */
package tcw_pkg;

  // Screen geometry defaults
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Field widths fixed by the interface
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int COLOR_W  = 4;

  // Action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Tab stop mask (multiples of eight)
  localparam logic [7:0] TAB_MASK = 8'hF8;

  // Cell value held by every entry after reset
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // Register indexes and reset values
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

endpackage

/* rtl/tcw_screen_mem.sv */
module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH  = COLUMNS_DEFAULT * ROWS_DEFAULT,
  parameter int ADDR_W = $clog2(COLUMNS_DEFAULT * ROWS_DEFAULT)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tcw_ctrl.sv */
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter  int COLUMNS = COLUMNS_DEFAULT,
  parameter  int ROWS    = ROWS_DEFAULT,
  localparam int CELLS   = COLUMNS * ROWS,
  localparam int ADDR_W  = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_item_t          item,
  output logic              busy,
  input  logic [7:0]        attr,
  output logic              done,
  output out_item_t         result,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]        state;
  in_item_t          item_q;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] sweep_idx;
  logic              issue_on;
  logic              pipe_valid;
  logic [ADDR_W-1:0] pipe_dst;
  logic              pipe_copy;
  logic              copy_mode;
  logic              report;
  logic [CELL_W-1:0] fill;
  logic              data_sel;

  logic [ADDR_W-1:0] cur_lin;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        tab_sum;
  logic [7:0]        col_inc;
  logic [CELL_W-1:0] blank;
  logic              at_last_row;
  logic              tcol_ok;
  logic              trow_ok;
  logic              rd_ok;
  logic              copy_now;

  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic              nl;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              scroll;
  logic              clear;
  logic              rd;

  assign cur_lin     = ADDR_W'(cur_row) * ROW_STEP + ADDR_W'(cur_col);
  assign rd_idx      = ADDR_W'(item_q.target_row) * ROW_STEP + ADDR_W'(item_q.target_col);
  assign tab_sum     = (8'(cur_col) + 8'd8) & TAB_MASK;
  assign col_inc     = 8'(cur_col) + 8'd1;
  assign blank       = {attr, CH_SPACE};
  assign at_last_row = (cur_row == ROW_W'(ROWS - 1));
  assign tcol_ok     = ({1'b0, item_q.target_col} < 8'(COLUMNS));
  assign trow_ok     = ({1'b0, item_q.target_row} < 6'(ROWS));
  assign rd_ok       = tcol_ok && trow_ok;
  assign copy_now    = copy_mode && (sweep_idx < COPY_END);

  // Execute one item against the cursor
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    nl       = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = cur_lin;
    wr_data  = blank;
    scroll   = 1'b0;
    clear    = 1'b0;
    rd       = 1'b0;
    case (item_q.action)
      ACT_PUT: begin
        case (item_q.char_code)
          CH_LF: begin
            nl = 1'b1;
          end
          CH_CR: begin
            col_next = '0;
          end
          CH_TAB: begin
            if (tab_sum >= 8'(COLUMNS)) begin
              nl = 1'b1;
            end else begin
              col_next = COL_W'(tab_sum);
            end
          end
          CH_BS: begin
            if (cur_col != '0) begin
              col_next = cur_col - COL_W'(1);
              wr_en    = 1'b1;
              wr_addr  = cur_lin - ADDR_W'(1);
            end
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = {attr, item_q.char_code};
            if (col_inc >= 8'(COLUMNS)) begin
              nl = 1'b1;
            end else begin
              col_next = COL_W'(col_inc);
            end
          end
        endcase
      end
      ACT_SET: begin
        if (tcol_ok) begin
          col_next = COL_W'(item_q.target_col);
        end
        if (trow_ok) begin
          row_next = ROW_W'(item_q.target_row);
        end
      end
      ACT_CLEAR: begin
        row_next = '0;
        col_next = '0;
        clear    = 1'b1;
      end
      default: begin
        rd = 1'b1;
      end
    endcase
    if (nl) begin
      col_next = '0;
      if (at_last_row) begin
        scroll = 1'b1;
      end else begin
        row_next = cur_row + ROW_W'(1);
      end
    end
  end

  // Memory access: sweep write stage owns the write port while sweeping
  assign mem_we    = (state == ST_EXEC && wr_en) || (state == ST_SWEEP && pipe_valid);
  assign mem_waddr = (state == ST_SWEEP) ? pipe_dst : wr_addr;
  assign mem_wdata = (state == ST_SWEEP) ? (pipe_copy ? mem_rdata : fill) : wr_data;
  assign mem_re    = (state == ST_SWEEP && issue_on && copy_now) ||
                     (state == ST_EXEC && rd && rd_ok);
  assign mem_raddr = (state == ST_SWEEP) ? (sweep_idx + ROW_STEP) : rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      cur_row    <= '0;
      cur_col    <= '0;
      sweep_idx  <= '0;
      issue_on   <= 1'b1;
      pipe_valid <= 1'b0;
      copy_mode  <= 1'b0;
      report     <= 1'b0;
      fill       <= RESET_CELL;
      done       <= 1'b0;
      data_sel   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cur_row  <= row_next;
          cur_col  <= col_next;
          data_sel <= rd && rd_ok;
          if (scroll || clear) begin
            state     <= ST_SWEEP;
            issue_on  <= 1'b1;
            sweep_idx <= '0;
            copy_mode <= scroll;
            fill      <= blank;
            report    <= 1'b1;
          end else if (rd) begin
            state <= ST_READ;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_SWEEP: begin
          pipe_valid <= issue_on;
          if (issue_on) begin
            if (sweep_idx == LAST_CELL) begin
              issue_on <= 1'b0;
            end else begin
              sweep_idx <= sweep_idx + ADDR_W'(1);
            end
          end
          if (pipe_valid && pipe_dst == LAST_CELL) begin
            state      <= ST_IDLE;
            done       <= report;
            pipe_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      item_q <= item;
    end
    pipe_dst  <= sweep_idx;
    pipe_copy <= copy_now;
  end

  assign busy              = (state != ST_IDLE);
  assign result.cursor_pos = POS_W'(cur_lin);
  assign result.cell_data  = data_sel ? mem_rdata : '0;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe outside idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write of the same cell in one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < ROWS) && (32'(cur_col) < COLUMNS))
    else $error("cursor out of the screen");

  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !mem_we && !mem_re)
    else $error("memory access while read data is due");

endmodule

/* rtl/text_console_writer_unit.sv */
// Text console writer. A command is taken when start is high and busy is low;
// its single result appears for exactly one cycle with done high and cannot be
// held off, so capture it on that cycle. Put-character and set-cursor commands
// pass through execute and then the result cycle, during which the next
// command may already be taken; a cell read adds a read state between them,
// for the registered read of the screen memory. Clear, and any put that runs
// past the last row and scrolls, sweep the whole screen memory one cell per
// cycle through its single write port. After reset the block runs a clearing
// pass with busy high; colour registers may be written during it.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              start,
  input  in_item_t          item,
  output logic              busy,
  // result channel
  output logic              done,
  output out_item_t         result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic               cfg_wr;
  logic               reg_idx;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Registers sit on 32-bit word boundaries; the word index picks the colour.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FG:  fg_color <= pwdata[COLOR_W-1:0];
        REG_BG:  bg_color <= pwdata[COLOR_W-1:0];
        default: fg_color <= fg_color;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FG:  prdata = APB_DW'(fg_color);
      REG_BG:  prdata = APB_DW'(bg_color);
      default: prdata = '0;
    endcase
  end

  // Sequencer: owns the cursor and drives every screen memory access.
  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .attr      ({bg_color, fg_color}),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Screen store: one write port, one registered read port.
  tcw_screen_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* test/tb_top.sv */
module tb_top;
  import tcw_pkg::*;

  // Screen geometry under test; the block is built with the package defaults.
  localparam int COLS  = COLUMNS_DEFAULT;
  localparam int LINES = ROWS_DEFAULT;
  localparam int CELLS = COLS * LINES;
  localparam int TAB_STEP = 8;

  // The slowest correct run is dominated by full-screen sweeps, including the
  // clearing pass after reset. Sweeps are budgeted below, so the cycle limit
  // leaves a wide margin.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int SWEEP_BUDGET  = 45;
  localparam int PHASES        = 5;
  localparam int BEATS_A_PHASE = 166;

  // Expected cursor and cell data, worked out from a private copy of the screen.
  class console_scoreboard;
    logic [CELL_W-1:0]  cells [CELLS];
    int                 row;
    int                 col;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    out_item_t          pending_results [$];
    int                 failures;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      row      = 0;
      col      = 0;
      fg       = FG_RESET;
      bg       = BG_RESET;
      failures = 0;
    endfunction

    function logic [CELL_W-1:0] coloured(logic [7:0] ch);
      return {bg, fg, ch};
    endfunction

    function void next_line();
      col = 0;
      row++;
      if (row >= LINES) begin
        for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = coloured(CH_SPACE);
        row = LINES - 1;
      end
    endfunction

    function void place_byte(logic [7:0] ch);
      case (ch)
        CH_LF: next_line();
        CH_CR: col = 0;
        CH_TAB: begin
          col = int'(8'(col + TAB_STEP) & TAB_MASK);
          if (col >= COLS) next_line();
        end
        CH_BS: begin
          if (col > 0) begin
            col--;
            cells[row * COLS + col] = coloured(CH_SPACE);
          end
        end
        default: begin
          cells[row * COLS + col] = coloured(ch);
          col++;
          if (col >= COLS) next_line();
        end
      endcase
    endfunction

    // True when the command walks the whole store (clear, or a put that scrolls).
    function bit would_sweep(in_item_t it);
      if (it.action == ACT_CLEAR) return 1'b1;
      if (it.action != ACT_PUT || row != LINES - 1) return 1'b0;
      case (it.char_code)
        CH_LF:  return 1'b1;
        CH_CR, CH_BS: return 1'b0;
        CH_TAB: return int'(8'(col + TAB_STEP) & TAB_MASK) >= COLS;
        default: return col == COLS - 1;
      endcase
    endfunction

    function void note_command(in_item_t it);
      out_item_t want;
      want.cell_data = '0;
      case (it.action)
        ACT_PUT: place_byte(it.char_code);
        ACT_SET: begin
          if (it.target_col < COLS) col = it.target_col;
          if (it.target_row < LINES) row = it.target_row;
        end
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = coloured(CH_SPACE);
          row = 0;
          col = 0;
        end
        default: begin
          if (it.target_col < COLS && it.target_row < LINES)
            want.cell_data = cells[it.target_row * COLS + it.target_col];
        end
      endcase
      want.cursor_pos = POS_W'(row * COLS + col);
      pending_results.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: cursor_pos %0d cell_data %h",
                 $time, got.cursor_pos, got.cell_data);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.cursor_pos !== want.cursor_pos) begin
        $display("%0t: cursor_pos expected %0d actual %0d",
                 $time, want.cursor_pos, got.cursor_pos);
        failures++;
      end
      if (got.cell_data !== want.cell_data) begin
        $display("%0t: cell_data expected %h actual %h",
                 $time, want.cell_data, got.cell_data);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  in_item_t          cmd;
  logic              busy;
  logic              done;
  out_item_t         res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  console_scoreboard book = new();
  int                idle_pct;
  int                sweeps_left = SWEEP_BUDGET;
  int                cycles = 0;
  int                fg_plan   [PHASES] = '{15, 0, -1, 15, -1};
  int                bg_plan   [PHASES] = '{15, 0, -1, 0, -1};
  // The receiver cannot hold results off, so only the sender idles.
  int                idle_plan [PHASES] = '{0, 62, 34, 62, 0};

  text_console_writer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (cmd),
    .busy    (busy),
    .done    (done),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_writer_unit verification failed");
      $finish;
    end
  end

  // Results cannot be stalled: take each one on its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) book.check_result(res);
  end

  // Hold a command on the port until it is taken, with random idle cycles
  // beforehand. Entered just after a falling edge; returns just after one with
  // start still high, so the caller either raises the next beat or drops start.
  task automatic send_command(in_item_t it);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk); while (busy !== 1'b0);
    book.note_command(it);
    @(negedge clk);
  endtask

  // Drop start and wait until every result is back and the block is idle.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (book.pending_results.size() != 0 || busy !== 1'b0);
    @(negedge clk);
  endtask

  // Write one colour register, then read it back over the same port.
  task automatic program_colour(logic index, logic [COLOR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (index == REG_FG) book.fg = value;
    else book.bg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[COLOR_W-1:0] !== value) begin
      $display("%0t: colour register %0d expected %h actual %h",
               $time, index, value, prdata[COLOR_W-1:0]);
      book.failures++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic in_item_t make_cmd(logic [1:0] act, logic [7:0] ch,
                                        logic [6:0] c, logic [4:0] r);
    in_item_t it;
    it.action     = act;
    it.char_code  = ch;
    it.target_col = c;
    it.target_row = r;
    return it;
  endfunction

  // Mostly text with occasional control bytes, cursor moves and read-backs,
  // half of them near the cursor; scrolls and clears are rationed since each
  // one walks the whole screen.
  task automatic pick_command(output in_item_t it);
    int  roll;
    int  pick;
    bit  ok;
    do begin
      roll          = $urandom_range(0, 99);
      pick          = $urandom_range(0, 99);
      it.char_code  = 8'($urandom_range(0, 255));
      it.target_col = 7'($urandom_range(0, 127));
      it.target_row = 5'($urandom_range(0, 31));
      if (roll < 55) begin
        it.action = ACT_PUT;
        if (pick < 70) begin
          it.char_code = 8'($urandom_range(8'h20, 8'h7E));
        end else if (pick < 82) begin
          case ($urandom_range(0, 3))
            0: it.char_code = CH_LF;
            1: it.char_code = CH_CR;
            2: it.char_code = CH_TAB;
            default: it.char_code = CH_BS;
          endcase
        end
      end else if (roll < 70) begin
        it.action = ACT_SET;
        if (pick >= 20) begin
          it.target_col = 7'($urandom_range(0, COLS - 1));
          it.target_row = (pick < 40) ? 5'(LINES - 1) : 5'($urandom_range(0, LINES - 1));
        end
      end else if (roll < 72) begin
        it.action = ACT_CLEAR;
      end else begin
        it.action = ACT_READ;
        if (pick < 50) begin
          it.target_col = 7'((book.col > 0) ? book.col - 1 : 0);
          it.target_row = 5'(book.row);
        end else if (pick < 85) begin
          it.target_col = 7'($urandom_range(0, COLS - 1));
          it.target_row = 5'($urandom_range(0, LINES - 1));
        end
      end
      ok = !book.would_sweep(it) || (sweeps_left > 0 && $urandom_range(0, 99) < 40);
    end while (!ok);
    if (book.would_sweep(it)) sweeps_left--;
  endtask

  initial begin
    in_item_t directed [$];
    in_item_t it;
    start    = 1'b0;
    cmd      = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    rst      = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed beats under the reset colours; the first ones wait out the
    // clearing pass and check the blank screen it leaves.
    directed.push_back(make_cmd(ACT_READ, 8'hA5, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h5A, 7'd127, 5'd31));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 7'(COLS - 1), 5'(LINES - 1)));
    directed.push_back(make_cmd(ACT_PUT, 8'h41, 7'd127, 5'd31));
    directed.push_back(make_cmd(ACT_PUT, 8'hFF, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_PUT, 8'h00, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_PUT, CH_BS, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 7'd2, 5'd0));
    directed.push_back(make_cmd(ACT_PUT, CH_TAB, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_PUT, CH_CR, 7'd0, 5'd0));
    // backspace at column 0 must do nothing
    directed.push_back(make_cmd(ACT_PUT, CH_BS, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_PUT, CH_LF, 7'd0, 5'd0));
    // out-of-range coordinates are ignored one at a time
    directed.push_back(make_cmd(ACT_SET, 8'hFF, 7'd100, 5'd5));
    directed.push_back(make_cmd(ACT_SET, 8'h00, 7'd3, 5'd30));
    // tab from the last tab stop runs off the row
    directed.push_back(make_cmd(ACT_SET, 8'h00, 7'(COLS - 8), 5'd3));
    directed.push_back(make_cmd(ACT_PUT, CH_TAB, 7'd0, 5'd0));
    // wrap past the bottom corner scrolls
    directed.push_back(make_cmd(ACT_SET, 8'h00, 7'(COLS - 1), 5'(LINES - 1)));
    directed.push_back(make_cmd(ACT_PUT, 8'h5A, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 7'(COLS - 1), 5'(LINES - 2)));
    // newline on the last row scrolls too
    directed.push_back(make_cmd(ACT_PUT, CH_LF, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 7'(COLS - 1), 5'(LINES - 3)));
    directed.push_back(make_cmd(ACT_CLEAR, 8'hFF, 7'd127, 5'd31));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 7'd0, 5'd0));
    directed.push_back(make_cmd(ACT_SET, 8'h00, 7'd127, 5'd31));
    foreach (directed[i]) send_command(directed[i]);
    settle();

    // Random phases, each under its own colours and idling.
    for (int p = 0; p < PHASES; p++) begin
      program_colour(REG_FG, (fg_plan[p] < 0) ? 4'($urandom_range(0, 15)) : 4'(fg_plan[p]));
      program_colour(REG_BG, (bg_plan[p] < 0) ? 4'($urandom_range(0, 15)) : 4'(bg_plan[p]));
      idle_pct = idle_plan[p];
      for (int n = 0; n < BEATS_A_PHASE; n++) begin
        pick_command(it);
        send_command(it);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.failures == 0) begin
      $display("text_console_writer_unit verification clean");
    end else begin
      $display("text_console_writer_unit verification failed");
    end
    $finish;
  end

endmodule
